FILE: rtl/sensor_scratchpad_crc_decoder_unit_assert.svh
// assertion macros shared by the scratchpad decoder modules
`ifndef SENSOR_SCRATCHPAD_CRC_DECODER_UNIT_ASSERT_SVH
`define SENSOR_SCRATCHPAD_CRC_DECODER_UNIT_ASSERT_SVH

// property that holds at every clock edge out of reset
`define SSDEC_ASSERT_HOLDS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");

// same-cycle implication
`define SSDEC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SSDEC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/ssdec_pkg.sv
// shared types, constants and crc function for the scratchpad decoder
package ssdec_pkg;

  localparam logic [7:0] CrcPoly   = 8'h8C;
  localparam logic [3:0] LastIndex = 4'd8;

  typedef struct packed {
    logic signed [16:0] temperature_sixteenths;
    logic               crc_ok;
  } result_t;

  typedef struct packed {
    logic [3:0] idx;
    logic       last;
    logic [7:0] crc_next;
  } step_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    c = crc_in;
    d = data;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ d[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

FILE: rtl/ssdec_core.sv
// per-byte decode: position, crc update and temperature conversion
module ssdec_core (
  input  logic [3:0]         byte_index_i,
  input  logic [7:0]         crc_i,
  input  logic [7:0]         temp_lo_i,
  input  logic [7:0]         temp_hi_i,
  input  logic [7:0]         data_byte_i,
  input  logic               frame_start_i,
  output ssdec_pkg::step_t   step_o,
  output ssdec_pkg::result_t result_o
);

  logic [3:0]  idx_raw;
  logic [3:0]  idx;
  logic [7:0]  crc_seed;
  logic [15:0] raw;

  assign idx_raw  = frame_start_i ? 4'd0 : byte_index_i;
  assign idx      = (idx_raw > ssdec_pkg::LastIndex) ? 4'd0 : idx_raw;
  assign crc_seed = (idx == 4'd0) ? 8'd0 : crc_i;

  assign step_o.idx      = idx;
  assign step_o.last     = (idx == ssdec_pkg::LastIndex);
  assign step_o.crc_next = ssdec_pkg::crc8_byte(crc_seed, data_byte_i);

  // any of the top four bits set means a negative reading
  assign raw = {temp_hi_i, temp_lo_i};
  assign result_o.temperature_sixteenths = (|raw[15:12]) ? $signed({1'b1, raw})
                                                         : $signed({1'b0, raw});
  assign result_o.crc_ok = (crc_i == data_byte_i);

endmodule

FILE: rtl/ssdec_obuf.sv
// two-entry result buffer: output register plus skid slot
`include "sensor_scratchpad_crc_decoder_unit_assert.svh"

module ssdec_obuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ssdec_pkg::result_t push_data_i,
  output logic               can_push_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ssdec_pkg::result_t out_data_o
);

  logic               o_vld_q, o_vld_d;
  logic               s_vld_q, s_vld_d;
  ssdec_pkg::result_t o_data_q, o_data_d;
  ssdec_pkg::result_t s_data_q, s_data_d;
  logic               pop;

  assign pop         = o_vld_q && out_ready_i;
  assign can_push_o  = !s_vld_q;
  assign out_valid_o = o_vld_q;
  assign out_data_o  = o_data_q;

  always_comb begin
    o_vld_d  = o_vld_q;
    s_vld_d  = s_vld_q;
    o_data_d = o_data_q;
    s_data_d = s_data_q;
    if (s_vld_q) begin
      if (pop) begin
        o_data_d = s_data_q;
        s_vld_d  = 1'b0;
      end
    end else if (push_i) begin
      if (!o_vld_q || pop) begin
        o_data_d = push_data_i;
        o_vld_d  = 1'b1;
      end else begin
        s_data_d = push_data_i;
        s_vld_d  = 1'b1;
      end
    end else if (pop) begin
      o_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
      s_vld_q <= 1'b0;
    end else begin
      o_vld_q <= o_vld_d;
      s_vld_q <= s_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    o_data_q <= o_data_d;
    s_data_q <= s_data_d;
  end

  `SSDEC_ASSERT_IMP(a_skid_behind_out, s_vld_q, o_vld_q)
  `SSDEC_ASSERT_IMP(a_no_overflow, push_i, !s_vld_q)
  `SSDEC_ASSERT_NEXT(a_stall_fills_skid, push_i && o_vld_q && !out_ready_i, s_vld_q)

endmodule

FILE: rtl/sensor_scratchpad_crc_decoder_unit.sv
// top level of the scratchpad decoder with crc-8 check
`include "sensor_scratchpad_crc_decoder_unit_assert.svh"

// Takes the nine scratchpad bytes of a one-wire temperature sensor, one byte per
// transfer, and after byte 8 delivers one result: the temperature in signed
// sixteenths of a degree and crc_ok, set when byte 8 equals the reflected CRC-8
// (poly 0x8C) of bytes 0 to 7. frame_start marks byte 0 and restarts the count.
// A byte is taken every cycle unless the input stalls; each byte waits in the input
// register, and the result of byte 8 passes from there into the result buffer.
// A two-entry result buffer lets input keep flowing while a result waits; input
// stalls only when both entries are full and byte 8 sits in the input register.
module sensor_scratchpad_crc_decoder_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               frame_start_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [16:0] temperature_sixteenths_o,
  output logic               crc_ok_o
);

  logic               in_vld_q;
  logic [7:0]         data_q;
  logic               start_q;
  logic [3:0]         byte_index_q, byte_index_d;
  logic [7:0]         crc_q, crc_d;
  logic [7:0]         temp_lo_q;
  logic [7:0]         temp_hi_q;
  logic               adv;
  logic               can_push;
  ssdec_pkg::step_t   step;
  ssdec_pkg::result_t result;
  ssdec_pkg::result_t out_data;

  ssdec_core u_core (
    .byte_index_i  (byte_index_q),
    .crc_i         (crc_q),
    .temp_lo_i     (temp_lo_q),
    .temp_hi_i     (temp_hi_q),
    .data_byte_i   (data_q),
    .frame_start_i (start_q),
    .step_o        (step),
    .result_o      (result)
  );

  assign adv        = in_vld_q && (!step.last || can_push);
  assign in_ready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q  <= data_byte_i;
      start_q <= frame_start_i;
    end
  end

  always_comb begin
    byte_index_d = byte_index_q;
    crc_d        = crc_q;
    if (adv) begin
      if (step.last) begin
        byte_index_d = 4'd0;
      end else begin
        byte_index_d = 4'(step.idx + 4'd1);
        crc_d        = step.crc_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= 4'd0;
      crc_q        <= 8'd0;
    end else begin
      byte_index_q <= byte_index_d;
      crc_q        <= crc_d;
    end
  end

  // temperature bytes 0 and 1
  always_ff @(posedge clk_i) begin
    if (adv && step.idx == 4'd0) begin
      temp_lo_q <= data_q;
    end
    if (adv && step.idx == 4'd1) begin
      temp_hi_q <= data_q;
    end
  end

  ssdec_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (adv && step.last),
    .push_data_i (result),
    .can_push_o  (can_push),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign temperature_sixteenths_o = out_data.temperature_sixteenths;
  assign crc_ok_o                 = out_data.crc_ok;

  `SSDEC_ASSERT_HOLDS(a_index_in_range, byte_index_q <= ssdec_pkg::LastIndex)
  `SSDEC_ASSERT_NEXT(a_last_wraps, adv && step.last, byte_index_q == 4'd0)
  `SSDEC_ASSERT_NEXT(a_byte_counts, adv && !step.last, byte_index_q != 4'd0)

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the scratchpad decoder with crc-8 check
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned NumRandomItems = 850;
  localparam int unsigned MaxReports     = 10;
  localparam int unsigned DrainCycles    = 16;
  localparam logic [15:0] NegMask        = 16'hF000;

  typedef enum int unsigned {
    FillRandom,
    FillZero,
    FillOnes
  } fill_e;

  typedef struct {
    logic [7:0] data;
    logic       start;
    bit         drain;
  } byte_xfer_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         data_byte = 8'h00;
  logic               frame_start = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [16:0] temperature;
  logic               crc_ok;

  byte_xfer_t           pending_bytes[$];
  ssdec_pkg::result_t   expected_readings[$];
  int unsigned          mismatch_count = 0;

  // decoder state as the prediction sees it
  logic [3:0] pd_index = 4'd0;
  logic [7:0] pd_crc   = 8'h00;
  logic [7:0] pd_lo    = 8'h00;
  logic [7:0] pd_hi    = 8'h00;

  sensor_scratchpad_crc_decoder_unit u_top (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .in_valid_i               (in_valid),
    .in_ready_o               (in_ready),
    .data_byte_i              (data_byte),
    .frame_start_i            (frame_start),
    .out_valid_o              (out_valid),
    .out_ready_i              (out_ready),
    .temperature_sixteenths_o (temperature),
    .crc_ok_o                 (crc_ok)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // reflected crc-8, lsb first
  function automatic logic [7:0] crc_shift_in(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    logic [7:0] d;
    logic       fb;
    c = crc;
    d = b;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ d[0];
      c  = c >> 1;
      if (fb) begin
        c = c ^ ssdec_pkg::CrcPoly;
      end
      d = d >> 1;
    end
    return c;
  endfunction

  function automatic void decode_scratchpad_byte(logic [7:0] b, logic start);
    logic [3:0]         idx;
    logic [15:0]        raw;
    logic [16:0]        val;
    ssdec_pkg::result_t reading;
    idx = start ? 4'd0 : pd_index;
    if (idx > ssdec_pkg::LastIndex) begin
      idx = 4'd0;
    end
    if (idx == ssdec_pkg::LastIndex) begin
      raw = {pd_hi, pd_lo};
      val = {1'b0, raw};
      if ((raw & NegMask) != 16'h0000) begin
        val = val - 17'h10000;
      end
      reading.temperature_sixteenths = val;
      reading.crc_ok                 = (pd_crc == b);
      expected_readings.push_back(reading);
      pd_index = 4'd0;
    end else begin
      pd_crc = crc_shift_in((idx == 4'd0) ? 8'h00 : pd_crc, b);
      if (idx == 4'd0) begin
        pd_lo = b;
      end else if (idx == 4'd1) begin
        pd_hi = b;
      end
      pd_index = idx + 4'd1;
    end
  endfunction

  function automatic int unsigned idle_len(bit steady);
    int unsigned r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_raw_word();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'h0FFF;
      2: return 16'h1000;
      3: return 16'hFFFF;
      4: return 16'hF000;
      5: return 16'($urandom_range(0, 16'h07FF));
      6: return 16'hFFFF - 16'($urandom_range(0, 16'h0370));
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic add_byte(logic [7:0] d, logic s, bit drain);
    byte_xfer_t x;
    x.data  = d;
    x.start = s;
    x.drain = drain;
    pending_bytes.push_back(x);
  endtask

  task automatic add_frame(logic [15:0] raw, bit good_crc, logic start, bit drain,
                           fill_e fill, int unsigned keep);
    logic [7:0] bytes[9];
    logic [7:0] c;
    bytes[0] = raw[7:0];
    bytes[1] = raw[15:8];
    for (int k = 2; k < 8; k++) begin
      case (fill)
        FillZero: bytes[k] = 8'h00;
        FillOnes: bytes[k] = 8'hFF;
        default:  bytes[k] = 8'($urandom_range(0, 255));
      endcase
    end
    c = 8'h00;
    for (int k = 0; k < 8; k++) begin
      c = crc_shift_in(c, bytes[k]);
    end
    bytes[8] = good_crc ? c : c ^ 8'($urandom_range(1, 255));
    for (int k = 0; k < int'(keep); k++) begin
      add_byte(bytes[k], (k == 0) ? start : 1'b0, (k == 0) && drain);
    end
  endtask

  // stimulus
  initial begin
    int unsigned base;
    int unsigned n;
    bit          aligned;
    bit          drain;
    add_frame(16'hFFFF, 1'b1, 1'b1, 1'b0, FillZero, 9);
    // next read begins right after byte 8 without a frame mark, bad crc
    add_frame(16'h0FFF, 1'b0, 1'b0, 1'b0, FillOnes, 9);
    // cut short, then restarted by a frame mark
    add_frame(16'h1234, 1'b1, 1'b1, 1'b0, FillRandom, 2);
    add_frame(16'h1000, 1'b1, 1'b1, 1'b1, FillRandom, 9);
    aligned = 1'b1;
    base    = pending_bytes.size();
    while (pending_bytes.size() < base + NumRandomItems) begin
      drain = ($urandom_range(0, 49) == 0);
      case ($urandom_range(0, 9))
        0: begin
          n = $urandom_range(1, 12);
          for (int i = 0; i < int'(n); i++) begin
            add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0, drain && i == 0);
          end
          aligned = 1'b0;
        end
        1: begin
          add_frame(pick_raw_word(), $urandom_range(0, 3) != 0, 1'b1, drain, FillRandom,
                    $urandom_range(1, 8));
          aligned = 1'b0;
        end
        default: begin
          add_frame(pick_raw_word(), $urandom_range(0, 3) != 0,
                    (aligned && $urandom_range(0, 3) == 0) ? 1'b0 : 1'b1, drain,
                    fill_e'($urandom_range(0, 9) < 8 ? FillRandom : $urandom_range(1, 2)), 9);
          aligned = 1'b1;
        end
      endcase
    end
  end

  // byte sender
  int unsigned tx_gap = 0;
  bit          tx_steady = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid    <= 1'b0;
      data_byte   <= 8'h00;
      frame_start <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_scratchpad_byte(data_byte, frame_start);
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0 &&
                     !(pending_bytes[0].drain && expected_readings.size() > 0)) begin
          in_valid    <= 1'b1;
          data_byte   <= pending_bytes[0].data;
          frame_start <= pending_bytes[0].start;
          void'(pending_bytes.pop_front());
          if ($urandom_range(0, 59) == 0) begin
            tx_steady = !tx_steady;
          end
          tx_gap = idle_len(tx_steady);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver and checker
  int unsigned rx_gap = 0;
  bit          rx_steady = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $display("unexpected result: temp %0d crc_ok %0b", temperature, crc_ok);
          end
        end else begin
          if (temperature !== expected_readings[0].temperature_sixteenths ||
              crc_ok !== expected_readings[0].crc_ok) begin
            mismatch_count++;
            if (mismatch_count <= MaxReports) begin
              $display("mismatch: temp exp %0d got %0d, crc_ok exp %0b got %0b",
                       expected_readings[0].temperature_sixteenths, temperature,
                       expected_readings[0].crc_ok, crc_ok);
            end
          end
          void'(expected_readings.pop_front());
        end
      end
      if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 79) == 0) begin
          rx_steady = !rx_steady;
        end
        if (!rx_steady && $urandom_range(0, 3) == 0) begin
          rx_gap = idle_len(1'b0);
        end
      end
    end
  end

  // end of run
  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    while (pending_bytes.size() > 0 || in_valid) begin
      @(posedge clk_i);
    end
    while (expected_readings.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_readings.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/ssdec_pkg.sv
rtl/ssdec_core.sv
rtl/ssdec_obuf.sv
rtl/sensor_scratchpad_crc_decoder_unit.sv
tb/tb_top.sv
